// ===== hdl/dfa_pkg.sv =====
// Package of the table-driven DFA matcher: request codes, register indexes,
// table geometry and reset values. No dependencies.
package dfa_pkg;

  localparam int unsigned MAX_STATES  = 256;
  localparam int unsigned MAX_SYMBOLS = 32;
  localparam int unsigned STATE_W     = $clog2(MAX_STATES);
  localparam int unsigned SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int unsigned TRANS_DEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int unsigned TRANS_AW    = STATE_W + SYM_W;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned NEXT_W  = 9;
  localparam int unsigned ALPH_W  = 6;
  localparam int unsigned CFG_W   = 9;

  localparam logic [CODE_W-1:0]  CHAR_BASE    = 8'd97;
  localparam logic [NEXT_W-1:0]  DEAD_STATE   = 9'h1FF;
  localparam logic [STATE_W-1:0] START_STATE  = '0;
  localparam logic [ALPH_W-1:0]  ALPH_RESET   = 6'd26;
  localparam logic [CFG_W-1:0]   STATES_RESET = 9'd256;

  typedef enum logic [1:0] {
    REQ_LOAD_TRANS = 2'd0,
    REQ_LOAD_FLAG  = 2'd1,
    REQ_FEED       = 2'd2,
    REQ_END        = 2'd3
  } req_type_e;

  typedef enum logic {
    CFG_ALPHABET = 1'b0,
    CFG_STATES   = 1'b1
  } cfg_index_e;

endpackage

// ===== hdl/dfa_if.sv =====
// Valid/ready channels of the DFA matcher: request items, result items and
// configuration writes. Depends on dfa_pkg.
interface dfa_req_if import dfa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [STATE_W-1:0]       table_state;
  logic [SYM_W-1:0]         table_symbol;
  logic signed [NEXT_W-1:0] next_state;
  logic                     is_final;
  logic [CODE_W-1:0]        char_code;

  modport source (output valid, req_type, table_state, table_symbol, next_state,
                  is_final, char_code, input ready);
  modport sink (input valid, req_type, table_state, table_symbol, next_state,
                is_final, char_code, output ready);
endinterface

interface dfa_res_if import dfa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic signed [NEXT_W-1:0] end_state;

  modport source (output valid, accepted, end_state, input ready);
  modport sink (input valid, accepted, end_state, output ready);
endinterface

interface dfa_cfg_if import dfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/dfa_table_matcher.sv =====
// Top level of the table-driven DFA matcher: transition memory, accept-flag
// memory, the state read-modify-write loop and the result register.
// Depends on dfa_pkg and the channel interfaces in dfa_if.sv.
//
// Usage: req_i carries request items. Type 0 writes one transition entry,
// type 1 writes one accept flag, type 2 feeds one character and type 3 ends
// the string. Only an end item produces a result item on res_o, carrying the
// accept verdict and the end state (-1 when dead); the matcher then restarts
// in state 0. cfg_i writes alphabet_in_use (index 0) and states_in_use
// (index 1); it is always ready and should be used only while idle.
// Throughput is one item per cycle while req_i is ready: a character issues
// its transition read at acceptance and the next character takes its address
// straight from the registered read data, so the memory read loop sets the
// rate. An end item's result passes the read stage, then the output register.
// Reset puts the matcher in state 0, clears all accept flags and restores the
// register defaults; transition entries stay undefined until loaded.
// When the receiver stalls, one result waits in the output register while
// loads and characters keep flowing; a second end item then waits in the
// read stage and req_i drops ready until the output register drains.
module dfa_table_matcher import dfa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  dfa_cfg_if.sink  cfg_i,
  dfa_req_if.sink  req_i,
  dfa_res_if.source res_o
);

  logic [ALPH_W-1:0]  alph_q;
  logic [CFG_W-1:0]   states_q;
  logic [STATE_W-1:0] cur_q, cur_d;
  logic               dead_q, dead_d;

  logic               s2_valid_q, s2_valid_d;
  logic               s2_end_q;
  logic               s2_dead_q;
  logic [STATE_W-1:0] s2_state_q;

  logic [NEXT_W-1:0]  trans_mem [TRANS_DEPTH];
  logic [NEXT_W-1:0]  trans_rd_q;
  logic               flag_mem [MAX_STATES];
  logic [MAX_STATES-1:0] flag_vld_q;
  logic               flag_rd_q;
  logic               flag_hit_q;

  logic               res_valid_q, res_valid_d;
  logic               res_accepted_q;
  logic [NEXT_W-1:0]  res_end_state_q;

  req_type_e          req_kind;
  logic               req_fire;
  logic               s2_feed_go, s2_end_go;
  logic               feed_dead;
  logic [CODE_W-1:0]  sym_full;
  logic               early_dead;
  logic               s1_dead;
  logic               trans_we, trans_re, flag_we, flag_re, stage_load;
  logic [TRANS_AW-1:0] trans_waddr, trans_raddr;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alph_q   <= ALPH_RESET;
      states_q <= STATES_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_index_e'(cfg_i.index))
        CFG_ALPHABET: alph_q   <= cfg_i.data[ALPH_W-1:0];
        CFG_STATES:   states_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign req_kind  = req_type_e'(req_i.req_type);
  assign s2_feed_go = s2_valid_q && !s2_end_q;
  assign s2_end_go  = s2_valid_q && s2_end_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !(s2_valid_q && s2_end_q) || !res_valid_q || res_o.ready;
  assign req_fire = req_i.valid && req_i.ready;

  always_comb begin
    feed_dead = s2_dead_q || trans_rd_q[NEXT_W-1] || (trans_rd_q >= states_q);
    cur_d  = cur_q;
    dead_d = dead_q;
    if (s2_feed_go) begin
      cur_d  = trans_rd_q[STATE_W-1:0];
      dead_d = feed_dead;
    end else if (s2_end_go) begin
      cur_d  = START_STATE;
      dead_d = 1'b0;
    end
  end

  always_comb begin
    sym_full   = req_i.char_code - CHAR_BASE;
    early_dead = (req_i.char_code < CHAR_BASE)
              || ({1'b0, cur_d} >= states_q)
              || (sym_full[CODE_W-1:SYM_W] != '0)
              || (sym_full >= {2'b00, alph_q});
    trans_we   = 1'b0;
    trans_re   = 1'b0;
    flag_we    = 1'b0;
    flag_re    = 1'b0;
    s1_dead    = dead_d;
    case (req_kind)
      REQ_LOAD_TRANS: trans_we = req_fire;
      REQ_LOAD_FLAG:  flag_we  = req_fire;
      REQ_FEED: begin
        trans_re = req_fire;
        s1_dead  = dead_d || early_dead;
      end
      REQ_END:        flag_re  = req_fire;
      default: ;
    endcase
    stage_load  = trans_re || flag_re;
    trans_waddr = {req_i.table_state, req_i.table_symbol};
    trans_raddr = {cur_d, sym_full[SYM_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= $unsigned(req_i.next_state);
    end
    if (trans_re) begin
      trans_rd_q <= trans_mem[trans_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[req_i.table_state] <= req_i.is_final;
    end
    if (flag_re) begin
      flag_rd_q  <= flag_mem[cur_d];
      flag_hit_q <= flag_vld_q[cur_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_vld_q <= '0;
    end else if (flag_we) begin
      flag_vld_q[req_i.table_state] <= 1'b1;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (stage_load) begin
      s2_valid_d = 1'b1;
    end else if (s2_feed_go || s2_end_go) begin
      s2_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (s2_end_go) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= START_STATE;
      dead_q      <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      dead_q      <= dead_d;
      s2_valid_q  <= s2_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_load) begin
      s2_end_q   <= flag_re;
      s2_dead_q  <= s1_dead;
      s2_state_q <= cur_d;
    end
    if (s2_end_go) begin
      res_accepted_q  <= !s2_dead_q && flag_rd_q && flag_hit_q;
      res_end_state_q <= s2_dead_q ? DEAD_STATE : {1'b0, s2_state_q};
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.accepted  = res_accepted_q;
  assign res_o.end_state = $signed(res_end_state_q);

endmodule
